>>> design/srtu_pkg.sv
// shared types, codes and constants of the system register and trap unit
package srtu_pkg;

  // instruction codes carried in the mode field
  localparam logic [2:0] MODE_LDSR = 3'd0;
  localparam logic [2:0] MODE_STSR = 3'd1;
  localparam logic [2:0] MODE_EI   = 3'd2;
  localparam logic [2:0] MODE_DI   = 3'd3;
  localparam logic [2:0] MODE_RETI = 3'd4;
  localparam logic [2:0] MODE_TRAP = 3'd5;

  // system register numbers
  localparam logic [4:0] SR_EIPC  = 5'd0;
  localparam logic [4:0] SR_EIPSW = 5'd1;
  localparam logic [4:0] SR_FEPC  = 5'd2;
  localparam logic [4:0] SR_FEPSW = 5'd3;
  localparam logic [4:0] SR_ECR   = 5'd4;
  localparam logic [4:0] SR_PSW   = 5'd5;
  localparam logic [4:0] SR_CTBP  = 5'd20;

  // psw bit positions
  localparam int unsigned PSW_ID = 5;
  localparam int unsigned PSW_EP = 6;
  localparam int unsigned PSW_NP = 7;
  localparam logic [31:0] PSW_RESET = 32'h0000_0020;

  // trap handler addresses, also the cause codes
  localparam logic [31:0] TRAP_CODE_LO = 32'h0000_0040;
  localparam logic [31:0] TRAP_CODE_HI = 32'h0000_0050;
  localparam logic [4:0]  TRAP_LO_LAST = 5'h0F;
  localparam logic [31:0] ECR_KEEP     = 32'h0000_00FF;
  localparam logic [31:0] PC_STEP      = 32'h0000_0004;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  sysreg_id;
    logic [31:0] gpr_value;
    logic [4:0]  trap_vector;
    logic [31:0] current_pc;
  } srtu_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        gpr_write;
    logic [31:0] gpr_data;
    logic        status;
    logic        clear_nmi;
    logic        clear_isr_level;
  } srtu_rsp_t;

  // handshake between the input register and the execute stage
  typedef struct packed {
    logic valid;
    logic advance;
  } srtu_ctl_t;

  // true for the implemented system register numbers
  function automatic logic sr_id_valid(logic [4:0] id);
    logic ok;
    case (id)
      SR_EIPC, SR_EIPSW, SR_FEPC, SR_FEPSW, SR_ECR, SR_PSW, SR_CTBP: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> design/srtu_if.sv
// valid/ready channel interfaces for request and response beats
interface srtu_req_if;
  import srtu_pkg::*;
  logic      valid;
  logic      ready;
  srtu_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srtu_rsp_if;
  import srtu_pkg::*;
  logic      valid;
  logic      ready;
  srtu_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/srtu_in_stage.sv
// input register that captures one request beat
module srtu_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  srtu_req_if.sink            req_i,
  input  logic                out_free_i,
  output srtu_pkg::srtu_ctl_t ctl_o,
  output srtu_pkg::srtu_req_t item_o
);
  import srtu_pkg::*;

  logic      valid_q, valid_d;
  srtu_req_t data_q;
  logic      advance;
  logic      take;

  // item moves on when the result register can hold it
  assign advance     = valid_q & out_free_i;
  assign req_i.ready = ~valid_q | advance;
  assign take        = req_i.valid & req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= req_i.data;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.advance = advance;
  assign item_o        = data_q;
endmodule

>>> design/srtu_exec.sv
// system registers and the combinational execute logic
module srtu_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srtu_pkg::srtu_ctl_t ctl_i,
  input  srtu_pkg::srtu_req_t item_i,
  output srtu_pkg::srtu_rsp_t rsp_o
);
  import srtu_pkg::*;

  logic [31:0] eipc_q, eipc_d;
  logic [31:0] eipsw_q, eipsw_d;
  logic [31:0] fepc_q, fepc_d;
  logic [31:0] fepsw_q, fepsw_d;
  logic [31:0] ecr_q, ecr_d;
  logic [31:0] psw_q, psw_d;
  logic [31:0] ctbp_q, ctbp_d;
  logic [31:0] pc_plus4;
  logic [31:0] sr_rdata;
  logic [31:0] trap_code;
  logic        id_ok;

  assign pc_plus4  = item_i.current_pc + PC_STEP;
  assign id_ok     = sr_id_valid(item_i.sysreg_id);
  assign trap_code = (item_i.trap_vector <= TRAP_LO_LAST) ? TRAP_CODE_LO : TRAP_CODE_HI;

  // system register read mux
  always_comb begin
    case (item_i.sysreg_id)
      SR_EIPC:  sr_rdata = eipc_q;
      SR_EIPSW: sr_rdata = eipsw_q;
      SR_FEPC:  sr_rdata = fepc_q;
      SR_FEPSW: sr_rdata = fepsw_q;
      SR_ECR:   sr_rdata = ecr_q;
      SR_PSW:   sr_rdata = psw_q;
      SR_CTBP:  sr_rdata = ctbp_q;
      default:  sr_rdata = '0;
    endcase
  end

  // instruction decode and next state
  always_comb begin
    eipc_d  = eipc_q;
    eipsw_d = eipsw_q;
    fepc_d  = fepc_q;
    fepsw_d = fepsw_q;
    ecr_d   = ecr_q;
    psw_d   = psw_q;
    ctbp_d  = ctbp_q;
    rsp_o         = '0;
    rsp_o.next_pc = item_i.current_pc;
    case (item_i.mode)
      MODE_LDSR, MODE_STSR: begin
        if (!id_ok) begin
          rsp_o.status = 1'b1;
        end else begin
          rsp_o.next_pc = pc_plus4;
          if (item_i.mode == MODE_STSR) begin
            rsp_o.gpr_write = 1'b1;
            rsp_o.gpr_data  = sr_rdata;
          end else begin
            case (item_i.sysreg_id)
              SR_EIPC:  eipc_d  = item_i.gpr_value;
              SR_EIPSW: eipsw_d = item_i.gpr_value;
              SR_FEPC:  fepc_d  = item_i.gpr_value;
              SR_FEPSW: fepsw_d = item_i.gpr_value;
              SR_ECR:   ecr_d   = item_i.gpr_value;
              SR_PSW:   psw_d   = item_i.gpr_value;
              SR_CTBP:  ctbp_d  = item_i.gpr_value;
              default:  ;
            endcase
          end
        end
      end
      MODE_EI: begin
        psw_d[PSW_ID] = 1'b0;
        rsp_o.next_pc = pc_plus4;
      end
      MODE_DI: begin
        psw_d[PSW_ID] = 1'b1;
        rsp_o.next_pc = pc_plus4;
      end
      MODE_RETI: begin
        if (psw_q[PSW_EP]) begin
          rsp_o.next_pc = eipc_q;
          psw_d         = eipsw_q;
        end else if (psw_q[PSW_NP]) begin
          rsp_o.next_pc   = fepc_q;
          psw_d           = fepsw_q;
          rsp_o.clear_nmi = 1'b1;
        end else begin
          rsp_o.next_pc         = eipc_q;
          psw_d                 = eipsw_q;
          rsp_o.clear_isr_level = 1'b1;
        end
      end
      MODE_TRAP: begin
        eipc_d        = pc_plus4;
        eipsw_d       = psw_q;
        ecr_d         = (ecr_q & ECR_KEEP) | {trap_code[15:0], 16'h0000};
        psw_d         = psw_q;
        psw_d[PSW_EP] = 1'b1;
        psw_d[PSW_ID] = 1'b1;
        rsp_o.next_pc = trap_code;
      end
      default: ;
    endcase
  end

  // state commits only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eipc_q  <= '0;
      eipsw_q <= '0;
      fepc_q  <= '0;
      fepsw_q <= '0;
      ecr_q   <= '0;
      psw_q   <= PSW_RESET;
      ctbp_q  <= '0;
    end else if (ctl_i.valid && ctl_i.advance) begin
      eipc_q  <= eipc_d;
      eipsw_q <= eipsw_d;
      fepc_q  <= fepc_d;
      fepsw_q <= fepsw_d;
      ecr_q   <= ecr_d;
      psw_q   <= psw_d;
      ctbp_q  <= ctbp_d;
    end
  end
endmodule

>>> design/srtu_out_stage.sv
// result register that holds one response beat until taken
module srtu_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  srtu_pkg::srtu_rsp_t rsp_i,
  output logic                free_o,
  srtu_rsp_if.source          rsp_o
);
  import srtu_pkg::*;

  logic      valid_q, valid_d;
  srtu_rsp_t data_q;

  assign free_o = ~valid_q | rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.data  = data_q;
endmodule

>>> design/system_register_trap_unit.sv
// top level of the system register and trap unit
// Executes one system-control instruction (ldsr, stsr, ei, di, reti, trap) per
// request beat and returns one response beat for each. A request is captured in
// an input register, executed combinationally against the seven system registers
// and written to a result register, and the unit sustains one instruction per
// clock while the result register is free. System register state is read and
// updated in the execute stage for each instruction in order. A stalled response
// holds in the result register while an empty input register still takes the next request.
module system_register_trap_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtu_req_if.sink   req_i,
  srtu_rsp_if.source rsp_o
);
  import srtu_pkg::*;

  srtu_ctl_t ctl;
  srtu_req_t item;
  srtu_rsp_t rsp_next;
  logic      out_free;

  srtu_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .item_o     (item)
  );

  srtu_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .item_i (item),
    .rsp_o  (rsp_next)
  );

  srtu_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctl.advance),
    .rsp_i  (rsp_next),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );
endmodule

>>> design/srtu_checker.sv
// port-level checks of the system register and trap unit
module srtu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input srtu_pkg::srtu_rsp_t rsp_data_i
);
  import srtu_pkg::*;

  logic req_beat;
  assign req_beat = req_valid_i & req_ready_i;

  // a stalled response beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled response changed");

  // a fresh response follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_beat, 2))
    else $error("response without request");

  // an id error carries no register write and no pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status |->
      !rsp_data_i.gpr_write && !rsp_data_i.clear_nmi && !rsp_data_i.clear_isr_level)
    else $error("error response with side effects");

  // at most one interrupt controller pulse per return
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_data_i.clear_nmi && rsp_data_i.clear_isr_level))
    else $error("both clear pulses set");
endmodule

bind system_register_trap_unit srtu_checker u_srtu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
